/* rtl/odmp_pkg.sv */
// Package for the ordered-dither monochrome packer.
// Holds panel geometry, store sizing, item kind codes and the dither tables.
// No dependencies.
`default_nettype none

package odmp_pkg;

    localparam int PANEL_COLS  = 240;
    localparam int PANEL_ROWS  = 320;
    localparam int ROW_BYTES   = (PANEL_COLS + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_ROWS;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    localparam logic [7:0] PAPER_BYTE = 8'hFF;
    localparam logic [7:0] INK_BYTE   = 8'h00;

    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    // 5-bit channel widened to 8 bits, truncated
    localparam logic [7:0] WIDEN5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // 4x4 Bayer thresholds, indexed by {y[1:0], x[1:0]}
    localparam logic [7:0] BAYER [16] = '{
        8'd15,  8'd143, 8'd47,  8'd175,
        8'd207, 8'd79,  8'd239, 8'd111,
        8'd63,  8'd191, 8'd31,  8'd159,
        8'd255, 8'd127, 8'd223, 8'd95
    };

    // 6-bit channel widened to 8 bits: 4v plus v/21, truncated
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [1:0] frac;
        begin
            if (v == 6'd63)
            begin
                frac = 2'd3;
            end
            else if (v >= 6'd42)
            begin
                frac = 2'd2;
            end
            else if (v >= 6'd21)
            begin
                frac = 2'd1;
            end
            else
            begin
                frac = 2'd0;
            end
            widen6 = {v, 2'b00} + 8'(frac);
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/ordered_dither_mono_packer.sv */
// Ordered-dither monochrome packer: top level with the frame memory and its sequencer.
// Depends on odmp_pkg for geometry, kind codes and dither tables.
`default_nettype none

// One-bit-per-pixel framebuffer held in a synchronous memory of
// STORE_BYTES bytes (9600 at 240x320). A pixel write, byte read or unused kind
// passes from transfer through the read and modify steps to its result, and the
// next item is taken once the modify step has handed its result on, which a
// waiting result can stall; only an on-panel pixel writes the frame memory.
// A fill also delivers its result from the modify step and then sweeps the
// memory one byte a cycle with paper or ink before the next item is taken.
// After reset the same sweep writes white paper, during which no item is
// taken. The result register lets the next item be taken while a result waits.
module ordered_dither_mono_packer
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic [1:0]           kind,
    input  wire logic signed [11:0]   x_coord,
    input  wire logic signed [11:0]   y_coord,
    input  wire logic [15:0]          color,
    input  wire logic [13:0]          byte_address,
    input  wire logic                 fill_white,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [7:0]                read_data,
    output logic                      in_range
);

    import odmp_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_MOD   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [7:0]        clr_val_reg, clr_val_next;

    logic [1:0]        kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        bitsel_reg;
    logic [7:0]        thr_reg;
    logic [7:0]        r8_reg, g8_reg, b8_reg;
    logic              hit_reg;
    logic              fill_reg;
    logic              ink_reg;

    logic              result_valid_reg, result_valid_next;
    logic [7:0]        read_data_reg;
    logic              in_range_reg;

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    logic              take;
    logic              out_free;
    logic              pixel_hit;
    logic              read_hit;
    logic [ADDR_W-1:0] pix_addr;
    logic [15:0]       lum_sum;
    logic [7:0]        bit_mask;
    logic [7:0]        mod_byte;
    logic              load_result;

    assign item_stall   = (state_reg != ST_IDLE);
    assign take         = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign read_data    = read_data_reg;
    assign in_range     = in_range_reg;

    assign pixel_hit = !x_coord[11] && (x_coord[10:0] < 11'(PANEL_COLS))
                    && !y_coord[11] && (y_coord[10:0] < 11'(PANEL_ROWS));
    assign read_hit  = 32'(byte_address) < STORE_BYTES;
    assign pix_addr  = ADDR_W'(y_coord[10:0]) * ADDR_W'(ROW_BYTES)
                     + ADDR_W'(x_coord[10:3]);

    assign lum_sum = 16'(r8_reg) * 16'(LUMA_R)
                   + 16'(g8_reg) * 16'(LUMA_G)
                   + 16'(b8_reg) * 16'(LUMA_B);

    assign bit_mask = 8'h80 >> bitsel_reg;
    assign mod_byte = ink_reg ? (rd_data_reg & ~bit_mask) : (rd_data_reg | bit_mask);

    assign load_result = (state_reg == ST_MOD) && out_free;
    assign rd_en       = (state_reg == ST_READ);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = mod_byte;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = clr_val_reg;
        end
        else if (load_result && (kind_reg == KIND_PIXEL) && hit_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clr_val_next  = clr_val_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (out_free)
                begin
                    if (kind_reg == KIND_FILL)
                    begin
                        state_next    = ST_CLEAR;
                        clr_addr_next = '0;
                        clr_val_next  = fill_reg ? PAPER_BYTE : INK_BYTE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            clr_val_reg      <= PAPER_BYTE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            clr_val_reg      <= clr_val_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // hold the item for the read-modify-write pass
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= kind;
            bitsel_reg <= x_coord[2:0];
            thr_reg    <= BAYER[{y_coord[1:0], x_coord[1:0]}];
            r8_reg     <= WIDEN5[color[15:11]];
            g8_reg     <= widen6(color[10:5]);
            b8_reg     <= WIDEN5[color[4:0]];
            fill_reg   <= fill_white;
            if (kind == KIND_READ)
            begin
                addr_reg <= ADDR_W'(byte_address);
                hit_reg  <= read_hit;
            end
            else
            begin
                addr_reg <= pix_addr;
                hit_reg  <= (kind == KIND_PIXEL) && pixel_hit;
            end
        end
        if (state_reg == ST_READ)
        begin
            ink_reg <= lum_sum[15:8] <= thr_reg;
        end
        if (load_result)
        begin
            in_range_reg  <= hit_reg;
            read_data_reg <= ((kind_reg == KIND_READ) && hit_reg) ? rd_data_reg : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en && hit_reg)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

`ifndef SYNTHESIS
    a_take_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == ST_READ))
        else $error("accepted item did not start a memory read");

    a_result_from_mod: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_MOD))
        else $error("result raised outside the modify step");

    a_clear_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (32'(clr_addr_reg) < STORE_BYTES))
        else $error("clear sweep ran past the store");

    a_mod_write_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == ST_MOD)) |-> (hit_reg && (kind_reg == KIND_PIXEL)))
        else $error("frame write without an on-panel pixel");
`endif

endmodule

`default_nettype wire

/* tb/tb_ordered_dither_mono_packer.sv */
`timescale 1ns / 100ps
// Testbench for ordered_dither_mono_packer: directed and random pixel writes, byte reads,
// fills and spare kinds, checked against a shadow framebuffer with its own dither predictor.
// Depends on odmp_pkg and the RTL top level.

module tb_ordered_dither_mono_packer;
    import odmp_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_CHUNKS  = 4;
    localparam int CHUNK_OPS      = 220;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int TAIL_CYCLES    = 16;
    localparam int LONG_HOLD      = 150;

    // 4x4 thresholds, entry (y&3)*4 + (x&3) at bits 8i+7..8i
    localparam logic [127:0] DITHER_LEVELS = {
        8'd95,  8'd223, 8'd127, 8'd255,
        8'd159, 8'd31,  8'd191, 8'd63,
        8'd111, 8'd239, 8'd79,  8'd207,
        8'd175, 8'd47,  8'd143, 8'd15
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] color;
        logic [13:0] addr;
        logic        fill_white;
    } frame_op_t;

    typedef struct packed {
        logic [7:0] data;
        logic       hit;
    } frame_reply_t;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic [1:0]         kind = KIND_PIXEL;
    logic signed [11:0] x_coord = '0;
    logic signed [11:0] y_coord = '0;
    logic [15:0]        color = '0;
    logic [13:0]        byte_address = '0;
    logic               fill_white = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [7:0]         read_data;
    logic               in_range;

    logic [7:0]   shadow_frame [STORE_BYTES];
    frame_op_t    ops_to_send [$];
    frame_reply_t replies_due [$];
    frame_op_t    cur_op;
    frame_reply_t due_reply;
    int           errors = 0;
    int           hot_addr = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_tick = 0;
    int           hold_left = 0;
    int           idle_cycles = 0;
    logic         hold_window = 1'b0;
    logic         hold_done = 1'b0;
    rx_mode_t     stall_mode = RX_OPEN;

    ordered_dither_mono_packer u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .color        (color),
        .byte_address (byte_address),
        .fill_white   (fill_white),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_data    (read_data),
        .in_range     (in_range)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int luma_of(logic [15:0] c);
        int r;
        int g;
        int b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        r = r * 255 / 31;
        g = g * 255 / 63;
        b = b * 255 / 31;
        return (r * LUMA_R + g * LUMA_G + b * LUMA_B) >> 8;
    endfunction

    function automatic frame_reply_t apply_frame_op(frame_op_t op);
        frame_reply_t rep;
        int sx;
        int sy;
        int idx;
        logic [7:0] mask;
        logic [7:0] level;
        rep = '0;
        sx = $signed(op.x);
        sy = $signed(op.y);
        case (op.kind)
            KIND_PIXEL:
            begin
                if (sx >= 0 && sx < PANEL_COLS && sy >= 0 && sy < PANEL_ROWS)
                begin
                    idx   = sy * ROW_BYTES + sx / 8;
                    mask  = 8'h80 >> (sx % 8);
                    level = DITHER_LEVELS[((sy % 4) * 4 + sx % 4) * 8 +: 8];
                    if (luma_of(op.color) <= level)
                        shadow_frame[idx] = shadow_frame[idx] & ~mask;
                    else
                        shadow_frame[idx] = shadow_frame[idx] | mask;
                    rep.hit = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (op.addr < STORE_BYTES)
                begin
                    rep.data = shadow_frame[op.addr];
                    rep.hit  = 1'b1;
                end
            end
            KIND_FILL:
            begin
                for (idx = 0; idx < STORE_BYTES; idx++)
                    shadow_frame[idx] = op.fill_white ? PAPER_BYTE : INK_BYTE;
            end
            default:
            begin
            end
        endcase
        return rep;
    endfunction

    function automatic frame_op_t make_op(logic [1:0] k, int x, int y, logic [15:0] c,
                                          int a, logic fw);
        frame_op_t op;
        op.kind       = k;
        op.x          = 12'(x);
        op.y          = 12'(y);
        op.color      = c;
        op.addr       = 14'(a);
        op.fill_white = fw;
        return op;
    endfunction

    function automatic frame_op_t random_op();
        frame_op_t op;
        int sel;
        op.kind       = KIND_PIXEL;
        op.x          = 12'($urandom);
        op.y          = 12'($urandom);
        op.color      = 16'($urandom);
        op.addr       = 14'($urandom);
        op.fill_white = 1'($urandom);
        sel = $urandom_range(0, 999);
        if (sel < 4)
            op.kind = KIND_FILL;
        else if (sel < 30)
            op.kind = KIND_SPARE;
        else if (sel < 620)
        begin
            if (sel >= 100)
            begin
                if (sel < 360)
                begin
                    op.x = 12'($urandom_range(0, 31));
                    op.y = 12'($urandom_range(0, 7));
                end
                else
                begin
                    op.x = 12'($urandom_range(0, PANEL_COLS - 1));
                    op.y = 12'($urandom_range(0, PANEL_ROWS - 1));
                end
                hot_addr = int'(op.y) * ROW_BYTES + int'(op.x) / 8;
            end
        end
        else
        begin
            op.kind = KIND_READ;
            if (sel < 860)
                op.addr = 14'(hot_addr);
            else if (sel < 960)
                op.addr = 14'($urandom_range(0, STORE_BYTES - 1));
        end
        return op;
    endfunction

    task automatic wait_quiet();
        @(negedge clk);
        while (ops_to_send.size() != 0 || item_valid || replies_due.size() != 0)
            @(negedge clk);
    endtask

    // Sender: bursts of transfers with random gaps; payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
                replies_due.push_back(apply_frame_op(cur_op));
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (ops_to_send.size() > 0)
                begin
                    cur_op = ops_to_send.pop_front();
                    kind         <= cur_op.kind;
                    x_coord      <= cur_op.x;
                    y_coord      <= cur_op.y;
                    color        <= cur_op.color;
                    byte_address <= cur_op.addr;
                    fill_white   <= cur_op.fill_white;
                    item_valid   <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern redrawn at random on a stall_tick period, plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            stall_tick++;
            if (stall_tick % 128 == 0)
                stall_mode = rx_mode_t'($urandom_range(0, 3));
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_window && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                result_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    RX_OPEN:  result_stall <= 1'b0;
                    RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                    default:  result_stall <= stall_tick[2];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t ns: result with none due, read_data %02h in_range %b",
                         $time, read_data, in_range);
                errors++;
            end
            else
            begin
                due_reply = replies_due.pop_front();
                if (read_data !== due_reply.data)
                begin
                    $display("%0t ns: read_data expected %02h, actual %02h",
                             $time, due_reply.data, read_data);
                    errors++;
                end
                if (in_range !== due_reply.hit)
                begin
                    $display("%0t ns: in_range expected %b, actual %b",
                             $time, due_reply.hit, in_range);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < STORE_BYTES; i++)
            shadow_frame[i] = PAPER_BYTE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, STORE_BYTES - 1, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, STORE_BYTES, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, 16383, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, 0, 0, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, PANEL_COLS - 1, PANEL_ROWS - 1, 16'hFFFF, 0,
                                      1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, 0, 3, 16'hFFFF, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, 1, 0, 16'h8410, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, 2, 0, 16'h7BEF, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, -1, 0, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, PANEL_COLS, 0, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, 0, PANEL_ROWS, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, 0, -1, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, -2048, -2048, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, 2047, 2047, 16'hFFFF, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, 3 * ROW_BYTES, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, STORE_BYTES - 1, 1'b0));
        ops_to_send.push_back(make_op(KIND_SPARE, -1, -1, 16'hFFFF, 16383, 1'b1));
        ops_to_send.push_back(make_op(KIND_FILL, 0, 0, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, STORE_BYTES - 1, 1'b0));
        ops_to_send.push_back(make_op(KIND_PIXEL, 7, 0, 16'hFFFF, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, 0, 1'b0));
        ops_to_send.push_back(make_op(KIND_FILL, 0, 0, 16'h0000, 0, 1'b1));
        ops_to_send.push_back(make_op(KIND_READ, 0, 0, 16'h0000, 0, 1'b0));
        wait_quiet();

        for (int c = 0; c < RANDOM_CHUNKS; c++)
        begin
            for (int i = 0; i < CHUNK_OPS; i++)
                ops_to_send.push_back(random_op());
            if (c == 1)
                hold_window = 1'b1;
            wait_quiet();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
